// ===== hdl/rse_pkg.sv =====
// Shared constants, register indexes and types of the Reed-Solomon encoder.
package rse_pkg;

  localparam int SymBitsDef = 3;
  localparam int NparDef    = 2;
  localparam int QueueDepthDef = 2;

  localparam int CfgIdxW   = 1;
  localparam int FieldPolyW = 8;

  localparam logic [FieldPolyW-1:0] FieldPolyRst = 8'd3;
  localparam logic [63:0]           GenCoeffsRst = 64'd51;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFieldPoly = 1'b0,
    CfgGenCoeffs = 1'b1
  } rse_cfg_idx_e;

  typedef struct packed {
    logic last;
    logic too_long;
  } rse_flags_t;

endpackage

// ===== hdl/rse_front.sv =====
// Front end: configuration registers, symbol counter and parity division LFSR.
module rse_front #(
  parameter int SYM_BITS = rse_pkg::SymBitsDef,
  parameter int NPAR     = rse_pkg::NparDef,
  parameter int CFG_W    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [SYM_BITS-1:0]           in_sym_i,
  input  logic                          in_last_i,
  output logic                          in_ready_o,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output logic [SYM_BITS-1:0]           push_sym_o,
  output logic [NPAR*SYM_BITS-1:0]      push_par_o,
  output rse_pkg::rse_flags_t           push_flags_o
);
  import rse_pkg::*;

  localparam int GenW  = NPAR * SYM_BITS;
  localparam int Limit = (1 << SYM_BITS) - 1 - NPAR;

  logic [FieldPolyW-1:0] field_poly_q;
  logic [GenW-1:0]       gen_q;
  logic [SYM_BITS-1:0]   par_q [NPAR];
  logic [SYM_BITS-1:0]   par_d [NPAR];
  logic [SYM_BITS-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [SYM_BITS-1:0]   fb;
  logic                  tl;
  logic                  accept;

  function automatic logic [SYM_BITS-1:0] gf_mul(input logic [SYM_BITS-1:0] a,
                                                 input logic [SYM_BITS-1:0] b,
                                                 input logic [SYM_BITS-1:0] low);
    logic [SYM_BITS:0] acc;
    acc = '0;
    for (int i = SYM_BITS - 1; i >= 0; i--) begin
      acc = {acc[SYM_BITS-1:0], 1'b0};
      if (acc[SYM_BITS]) begin
        acc = {1'b0, acc[SYM_BITS-1:0] ^ low};
      end
      if (b[i]) begin
        acc = acc ^ {1'b0, a};
      end
    end
    return acc[SYM_BITS-1:0];
  endfunction

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
  assign tl      = (Limit < 0) || (int'({1'b0, cnt_inc}) > Limit);
  assign fb      = in_sym_i ^ par_q[NPAR-1];

  always_comb begin
    par_d[0] = gf_mul(fb, gen_q[0 +: SYM_BITS], field_poly_q[SYM_BITS-1:0]);
    for (int i = 1; i < NPAR; i++) begin
      par_d[i] = par_q[i-1] ^
                 gf_mul(fb, gen_q[i*SYM_BITS +: SYM_BITS], field_poly_q[SYM_BITS-1:0]);
    end
    for (int i = 0; i < NPAR; i++) begin
      push_par_o[i*SYM_BITS +: SYM_BITS] = par_d[i];
    end
  end

  assign cnt_d                 = in_last_i ? '0 : cnt_inc;
  assign push_sym_o            = in_sym_i;
  assign push_flags_o.last     = in_last_i;
  assign push_flags_o.too_long = tl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q <= FieldPolyRst;
      gen_q        <= GenW'(GenCoeffsRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFieldPoly: field_poly_q <= cfg_data_i[FieldPolyW-1:0];
        CfgGenCoeffs: gen_q        <= cfg_data_i[GenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < NPAR; i++) begin
        par_q[i] <= '0;
      end
    end else if (accept) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < NPAR; i++) begin
        par_q[i] <= in_last_i ? '0 : par_d[i];
      end
    end
  end

endmodule

// ===== hdl/rse_fifo.sv =====
// Short queue that carries encoded words from the front end to the output sequencer.
module rse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rse_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign push_ready_o = (int'(cnt_q) != DEPTH);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (int'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (int'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> push_ready_o)
    else $error("Queue written while full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> pop_valid_o)
    else $error("Queue read while empty.");

endmodule

// ===== hdl/rse_back.sv =====
// Output sequencer: echoes each message word and appends the parity words of a block.
module rse_back #(
  parameter int SYM_BITS = rse_pkg::SymBitsDef,
  parameter int NPAR     = rse_pkg::NparDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  logic [SYM_BITS-1:0]      q_sym_i,
  input  logic [NPAR*SYM_BITS-1:0] q_par_i,
  input  rse_pkg::rse_flags_t      q_flags_i,
  output logic                     q_pop_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic [SYM_BITS-1:0]      m_sym_o,
  output logic                     m_is_parity_o,
  output logic                     m_end_o,
  output logic                     m_too_long_o
);
  import rse_pkg::*;

  localparam int PhW = $clog2(NPAR + 1);

  logic [PhW-1:0]      ph_q, ph_d;
  logic                valid_q;
  logic [SYM_BITS-1:0] sym_q, sym_d;
  logic                par_q, end_q, tl_q;
  logic                load, fire, done;

  assign load = !valid_q || m_ready_i;
  assign fire = load && q_valid_i;
  assign done = (ph_q == '0) ? !q_flags_i.last : (int'(ph_q) == NPAR);
  assign q_pop_o = fire && done;
  assign ph_d = done ? '0 : ph_q + 1'b1;

  always_comb begin
    sym_d = q_sym_i;
    for (int j = 0; j < NPAR; j++) begin
      if (ph_q != '0 && int'(ph_q) == NPAR - j) begin
        sym_d = q_par_i[j*SYM_BITS +: SYM_BITS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ph_q    <= '0;
    end else begin
      if (load) begin
        valid_q <= q_valid_i;
      end
      if (fire) begin
        ph_q <= ph_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      sym_q <= sym_d;
      par_q <= (ph_q != '0);
      end_q <= (int'(ph_q) == NPAR);
      tl_q  <= q_flags_i.too_long;
    end
  end

  assign m_valid_o     = valid_q;
  assign m_sym_o       = sym_q;
  assign m_is_parity_o = par_q;
  assign m_end_o       = end_q;
  assign m_too_long_o  = tl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q && end_q |-> par_q)
    else $error("Block end flagged on a word that is not parity.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(ph_q) <= NPAR)
    else $error("Output phase ran past the parity count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (ph_q != '0) |-> q_valid_i && q_flags_i.last)
    else $error("Parity phase without a pending last word.");

endmodule

// ===== hdl/systematic_rs_encoder_top.sv =====
// Top level of the systematic Reed-Solomon encoder.
// Message words enter one per cycle while the queue has room and are echoed
// unchanged, each also divided into the parity LFSR; the word marked last is
// followed by NPAR parity words, highest degree first, the final one with tlast
// high. The output sequencer sends one word per cycle while tready is high, so
// a block of k message words gives k + NPAR output words. With an idle output,
// an accepted word is registered in the queue and then in the sequencer. The
// queue between the LFSR front end and the sequencer holds QUEUE_DEPTH words.
// Under a steady stream the input stalls while parity is sent. It also stalls
// whenever the queue fills during an output stall. The field polynomial
// (register 0) and the packed generator coefficients g0 upward (register 1) are
// loaded through the write port and take effect at the next accepted word.
module systematic_rs_encoder_top #(
  parameter int SYM_BITS    = rse_pkg::SymBitsDef,
  parameter int NPAR        = rse_pkg::NparDef,
  parameter int QUEUE_DEPTH = rse_pkg::QueueDepthDef,
  localparam int GenW  = NPAR * SYM_BITS,
  localparam int CfgW  = (GenW > rse_pkg::FieldPolyW) ? GenW : rse_pkg::FieldPolyW,
  localparam int DataW = ((SYM_BITS + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]             cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [DataW-1:0]            s_axis_tdata,  // msg_symbol
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [DataW-1:0]            m_axis_tdata,  // code_symbol
  output logic [1:0]                  m_axis_tuser,  // too_long, is_parity
  output logic                        m_axis_tlast
);
  import rse_pkg::*;

  localparam int QW = GenW + SYM_BITS + $bits(rse_flags_t);

  logic                push, push_ready, pop, pop_valid;
  logic [SYM_BITS-1:0] f_sym, b_sym, m_sym;
  logic [GenW-1:0]     f_par, b_par;
  rse_flags_t          f_flags, b_flags;
  logic [QW-1:0]       q_in, q_out;
  logic                m_par, m_tl;

  rse_front #(
    .SYM_BITS(SYM_BITS),
    .NPAR    (NPAR),
    .CFG_W   (CfgW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_sym_i    (s_axis_tdata[SYM_BITS-1:0]),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .push_o      (push),
    .push_ready_i(push_ready),
    .push_sym_o  (f_sym),
    .push_par_o  (f_par),
    .push_flags_o(f_flags)
  );

  assign q_in = {f_par, f_sym, f_flags};

  rse_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_in),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (q_out)
  );

  assign {b_par, b_sym, b_flags} = q_out;

  rse_back #(
    .SYM_BITS(SYM_BITS),
    .NPAR    (NPAR)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (pop_valid),
    .q_sym_i      (b_sym),
    .q_par_i      (b_par),
    .q_flags_i    (b_flags),
    .q_pop_o      (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_sym_o      (m_sym),
    .m_is_parity_o(m_par),
    .m_end_o      (m_axis_tlast),
    .m_too_long_o (m_tl)
  );

  assign m_axis_tdata = DataW'(m_sym);
  assign m_axis_tuser = {m_tl, m_par};

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the systematic Reed-Solomon encoder top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  localparam int SymBits = SymBitsDef;
  localparam int Npar    = NparDef;
  localparam int GenW    = Npar * SymBits;
  localparam int CfgW    = (GenW > FieldPolyW) ? GenW : FieldPolyW;
  localparam int DataW   = ((SymBits + 7) / 8) * 8;
  localparam int MaxCount = (1 << SymBits) - 1;
  localparam int MsgLimit = MaxCount - Npar;
  localparam int CycleLimit = 200000;

  typedef logic [SymBits-1:0] symbol_t;

  typedef struct packed {
    symbol_t symbol;
    logic    parity;
    logic    block_end;
    logic    too_long;
  } code_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  rse_cfg_idx_e     cfg_idx_i = CfgFieldPoly;
  logic [CfgW-1:0]  cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  systematic_rs_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  logic [FieldPolyW-1:0] field_poly_q = FieldPolyRst;
  logic [GenW-1:0]       gen_coeffs_q = GenCoeffsRst[GenW-1:0];
  symbol_t               parity_q [Npar];
  int                    msg_count_q = 0;
  code_word_t            pending_code_q [$];
  int                    mismatch_cnt = 0;
  int                    cycle_cnt = 0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    foreach (parity_q[i]) parity_q[i] = '0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic symbol_t gf_product(input symbol_t a, input symbol_t b);
    logic [SymBits:0] acc;
    acc = '0;
    for (int i = SymBits - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc[SymBits]) begin
        acc = {1'b0, acc[SymBits-1:0] ^ field_poly_q[SymBits-1:0]};
      end
      if (b[i]) begin
        acc[SymBits-1:0] = acc[SymBits-1:0] ^ a;
      end
    end
    return acc[SymBits-1:0];
  endfunction

  function automatic void encode_symbol(input symbol_t sym, input logic last);
    symbol_t feedback;
    logic    over;
    if (msg_count_q < MaxCount) msg_count_q++;
    over = (msg_count_q > MsgLimit);
    feedback = sym ^ parity_q[Npar-1];
    for (int i = Npar - 1; i > 0; i--) begin
      parity_q[i] = parity_q[i-1] ^ gf_product(feedback, gen_coeffs_q[i*SymBits +: SymBits]);
    end
    parity_q[0] = gf_product(feedback, gen_coeffs_q[SymBits-1:0]);
    pending_code_q.push_back('{sym, 1'b0, 1'b0, over});
    if (last) begin
      for (int i = Npar - 1; i >= 0; i--) begin
        pending_code_q.push_back('{parity_q[i], 1'b1, (i == 0), over});
      end
      foreach (parity_q[i]) parity_q[i] = '0;
      msg_count_q = 0;
    end
  endfunction

  always @(posedge clk_i) begin
    code_word_t got;
    code_word_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_symbol(s_axis_tdata[SymBits-1:0], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[SymBits-1:0], m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
        if (pending_code_q.size() == 0) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: unexpected word sym=%0d par=%b end=%b long=%b", $realtime,
                     got.symbol, got.parity, got.block_end, got.too_long);
          end
          mismatch_cnt++;
        end else begin
          want = pending_code_q.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: word mismatch expected sym=%0d par=%b end=%b long=%b, got sym=%0d par=%b end=%b long=%b",
                       $realtime, want.symbol, want.parity, want.block_end, want.too_long,
                       got.symbol, got.parity, got.block_end, got.too_long);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with tvalid still high.
  task automatic send_symbol(input symbol_t sym, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DataW'(sym);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_code_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input rse_cfg_idx_e idx, input logic [CfgW-1:0] value);
    case (idx)
      CfgFieldPoly: field_poly_q = value[FieldPolyW-1:0];
      CfgGenCoeffs: gen_coeffs_q = value[GenW-1:0];
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_block(input symbol_t syms [$]);
    foreach (syms[i]) send_symbol(syms[i], (i == syms.size() - 1));
  endtask

  task automatic test_default_encoding();
    send_block('{3'd0, 3'd7, 3'd5});
    send_block('{3'd7});
  endtask

  task automatic test_overlong_block();
    send_block('{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd6});
  endtask

  task automatic test_register_extremes();
    drain_outputs();
    write_reg(CfgFieldPoly, 8'hFF);
    write_reg(CfgGenCoeffs, 8'hFF);
    send_block('{3'd7, 3'd7});
    drain_outputs();
    write_reg(CfgFieldPoly, 8'h00);
    write_reg(CfgGenCoeffs, 8'h00);
    send_block('{3'd2, 3'd5});
    drain_outputs();
    write_reg(CfgFieldPoly, FieldPolyRst);
    write_reg(CfgGenCoeffs, GenCoeffsRst[CfgW-1:0]);
  endtask

  task automatic test_midblock_update();
    send_symbol(3'd4, 1'b0);
    send_symbol(3'd1, 1'b0);
    drain_outputs();
    write_reg(CfgGenCoeffs, 8'd37);
    write_reg(CfgFieldPoly, 8'd5);
    send_symbol(3'd6, 1'b1);
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int      sent;
    int      blocks;
    int      len;
    symbol_t sym;
    sent   = 0;
    blocks = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < n_items) begin
      if (blocks % 8 == 0) begin
        drain_outputs();
        if ($urandom_range(3) == 0) begin
          write_reg(CfgFieldPoly, FieldPolyRst);
          write_reg(CfgGenCoeffs, GenCoeffsRst[CfgW-1:0]);
        end else begin
          write_reg(CfgFieldPoly, CfgW'($urandom_range(255)));
          write_reg(CfgGenCoeffs, CfgW'($urandom_range(255)));
        end
      end
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 10);
      for (int i = 0; i < len; i++) begin
        sym = symbol_t'($urandom);
        send_symbol(sym, (i == len - 1));
      end
      sent += len;
      blocks++;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    tx_idle_pct = 14;
    rx_idle_pct = 88;
    test_default_encoding();
    test_overlong_block();
    test_register_extremes();
    test_midblock_update();
    test_random_traffic(150, 14, 88);
    test_random_traffic(150, 88, 14);
    test_random_traffic(160, 0, 0);
    s_axis_tvalid <= 1'b0;
    rx_idle_pct = 0;
    while (pending_code_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_code_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
